### src/psu_pkg.sv
// Shared types, constants and prediction functions for the PNG RGB scanline unfilter.
`default_nettype none

package psu_pkg;

	localparam int PSU_MAX_WIDTH = 2048;
	localparam int PSU_REQ_DEPTH = 4;
	localparam int PSU_RES_DEPTH = 2;
	localparam int PSU_COL_W = 11;
	localparam int PSU_ROW_W = 16;
	localparam int PSU_CFG_IDX_W = 2;
	localparam int PSU_CFG_DATA_W = 16;

	localparam logic [PSU_CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [PSU_CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [2:0] FILT_NONE = 3'd0;
	localparam logic [2:0] FILT_SUB = 3'd1;
	localparam logic [2:0] FILT_UP = 3'd2;
	localparam logic [2:0] FILT_AVG = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] filter;
		logic [PSU_COL_W-1:0] column;
		logic [PSU_ROW_W-1:0] row;
		logic last_pixel;
		logic err;
	} psu_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [PSU_COL_W-1:0] column;
		logic [PSU_ROW_W-1:0] row;
		logic last_pixel;
		logic status;
	} psu_res_t;

	function automatic logic [7:0] psu_paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic [7:0] pa;
		logic [7:0] pb;
		logic [9:0] ab;
		logic [9:0] cc;
		logic [9:0] pc;
		logic [7:0] res;
		pa = (b >= c) ? b - c : c - b;
		pb = (a >= c) ? a - c : c - a;
		ab = 10'(a) + 10'(b);
		cc = {1'b0, c, 1'b0};
		pc = (ab >= cc) ? ab - cc : cc - ab;
		if (pa <= pb && 10'(pa) <= pc) begin
			res = a;
		end else if (10'(pb) <= pc) begin
			res = b;
		end else begin
			res = c;
		end
		return res;
	endfunction

	function automatic logic [7:0] psu_predict(input logic [2:0] f, input logic [7:0] a,
		input logic [7:0] b, input logic [7:0] c);
		logic [8:0] sum;
		logic [7:0] res;
		sum = 9'(a) + 9'(b);
		case (f)
			FILT_SUB: res = a;
			FILT_UP: res = b;
			FILT_AVG: res = sum[8:1];
			FILT_PAETH: res = psu_paeth(a, b, c);
			default: res = 8'd0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

### src/psu_fifo.sv
// Small register queue with push/full and pop/valid sides.
`default_nettype none

module psu_fifo #(
	parameter int DW = 8,
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [DW-1:0] push_data,
	output logic full,
	input wire logic pop,
	output logic [DW-1:0] pop_data,
	output logic valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && valid;
	assign pop_data = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### src/psu_front.sv
// Byte parser: tracks filter/channel position and row/column, issues pixel and error requests.
`default_nettype none

module psu_front
	import psu_pkg::*;
#(
	parameter int MAX_WIDTH = PSU_MAX_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [7:0] data_byte,
	output logic full,
	input wire logic [11:0] image_width,
	input wire logic [15:0] image_height,
	output logic req_push,
	output psu_req_t req_data,
	input wire logic req_full
);

	localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

	typedef enum logic [4:0] {
		ST_FILT = 5'b00001,
		ST_RED = 5'b00010,
		ST_GREEN = 5'b00100,
		ST_BLUE = 5'b01000,
		ST_STOP = 5'b10000
	} psu_state_t;

	psu_state_t state_q;
	logic [2:0] filter_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [PSU_COL_W-1:0] col_q;
	logic [PSU_ROW_W-1:0] row_q;

	logic take;
	logic bad_filter;
	logic [WW-1:0] w_ext;
	logic [WW-1:0] w_eff;
	logic [15:0] h_eff;
	logic row_end;
	logic img_end;

	assign full = req_full;
	assign take = push && !req_full;
	assign bad_filter = (data_byte > 8'(FILT_PAETH));

	always_comb begin
		w_ext = WW'(image_width);
		if (image_width == 12'd0) begin
			w_eff = WW'(1);
		end else if (w_ext > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
		row_end = (WW'(col_q) + WW'(1)) >= w_eff;
		img_end = (17'(row_q) + 17'd1) >= {1'b0, h_eff};
	end

	always_comb begin
		req_push = 1'b0;
		req_data = '0;
		req_data.column = col_q;
		req_data.row = row_q;
		req_data.filter = filter_q;
		req_data.red = red_q;
		req_data.green = green_q;
		req_data.blue = data_byte;
		req_data.last_pixel = row_end && img_end;
		case (state_q)
			ST_FILT: begin
				req_push = take && bad_filter;
				req_data.err = 1'b1;
			end
			ST_BLUE: req_push = take;
			default: req_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILT;
			filter_q <= FILT_NONE;
			red_q <= '0;
			green_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			case (state_q)
				ST_FILT: begin
					if (bad_filter) begin
						state_q <= ST_STOP;
					end else begin
						filter_q <= data_byte[2:0];
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					red_q <= data_byte;
					state_q <= ST_GREEN;
				end
				ST_GREEN: begin
					green_q <= data_byte;
					state_q <= ST_BLUE;
				end
				ST_BLUE: begin
					if (row_end) begin
						col_q <= '0;
						state_q <= ST_FILT;
						row_q <= img_end ? '0 : row_q + PSU_ROW_W'(1);
					end else begin
						col_q <= col_q + PSU_COL_W'(1);
						state_q <= ST_RED;
					end
				end
				default: state_q <= ST_STOP;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/psu_back.sv
// Pixel reconstruction: line store read, neighbor selection, filter undo, result push.
`default_nettype none

module psu_back
	import psu_pkg::*;
#(
	parameter int MAX_WIDTH = PSU_MAX_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire psu_req_t req_data,
	output logic req_pop,
	output logic res_push,
	output psu_res_t res_data,
	input wire logic res_full
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [23:0] row_mem [MAX_WIDTH];

	psu_req_t req_s1;
	logic valid_s1;
	logic [23:0] rd_s1;
	logic [23:0] fwd_s1;
	logic fwd_hit_s1;
	logic [23:0] left_q;
	logic [23:0] ul_q;

	logic done_s1;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [23:0] up_px;
	logic [23:0] left_px;
	logic [23:0] ul_px;
	logic [23:0] px;

	assign done_s1 = valid_s1 && !res_full;
	assign req_pop = req_valid && (!valid_s1 || done_s1);
	assign res_push = done_s1;
	assign wr_en = done_s1 && !req_s1.err;
	assign wr_addr = AW'(req_s1.column);
	assign rd_addr = AW'(req_data.column);

	always_comb begin
		up_px = '0;
		if (req_s1.row != '0) begin
			up_px = fwd_hit_s1 ? fwd_s1 : rd_s1;
		end
		left_px = (req_s1.column == '0) ? '0 : left_q;
		ul_px = (req_s1.column == '0 || req_s1.row == '0) ? '0 : ul_q;
		px[23:16] = req_s1.red + psu_predict(req_s1.filter, left_px[23:16], up_px[23:16],
			ul_px[23:16]);
		px[15:8] = req_s1.green + psu_predict(req_s1.filter, left_px[15:8], up_px[15:8],
			ul_px[15:8]);
		px[7:0] = req_s1.blue + psu_predict(req_s1.filter, left_px[7:0], up_px[7:0],
			ul_px[7:0]);
	end

	always_comb begin
		res_data.column = req_s1.column;
		res_data.row = req_s1.row;
		if (req_s1.err) begin
			res_data.red = '0;
			res_data.green = '0;
			res_data.blue = '0;
			res_data.last_pixel = 1'b0;
			res_data.status = 1'b1;
		end else begin
			res_data.red = px[23:16];
			res_data.green = px[15:8];
			res_data.blue = px[7:0];
			res_data.last_pixel = req_s1.last_pixel;
			res_data.status = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[wr_addr] <= px;
		end
		if (req_pop) begin
			rd_s1 <= row_mem[rd_addr];
			fwd_hit_s1 <= wr_en && (wr_addr == rd_addr);
			fwd_s1 <= px;
			req_s1 <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			left_q <= '0;
			ul_q <= '0;
		end else begin
			if (req_pop) begin
				valid_s1 <= 1'b1;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				left_q <= px;
				ul_q <= up_px;
			end
		end
	end

endmodule

`default_nettype wire

### src/png_rgb_scanline_unfilter.sv
// Top level of the PNG RGB scanline unfilter: config registers, parser, request queue, back end.
`default_nettype none

// Takes one stream byte per clock while the request queue has room (filter byte, then R, G,
// B per pixel) and returns one decoded pixel per blue byte; the back end retires up to one
// request per clock while the result queue has room, bounded by its single line-store read
// port, and a pixel goes from the request queue through the back end's s1 register into the
// result queue. A filter byte above 4 yields one result with status set and the block then
// drops all bytes until reset. The line store needs no clearing after reset; row 0 uses black
// as its upper neighbor. Write image_width and image_height only while no pixel is in flight.
module png_rgb_scanline_unfilter
	import psu_pkg::*;
#(
	parameter int MAX_WIDTH = PSU_MAX_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [7:0] data_byte,
	output logic empty,
	input wire logic pop,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [PSU_COL_W-1:0] column,
	output logic [PSU_ROW_W-1:0] row,
	output logic last_pixel,
	output logic status,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [PSU_CFG_IDX_W-1:0] cfg_index,
	input wire logic [PSU_CFG_DATA_W-1:0] cfg_data
);

	logic [11:0] width_q;
	logic [15:0] height_q;

	logic fr_push;
	psu_req_t fr_req;
	logic mid_full;
	logic mid_valid;
	logic mid_pop;
	logic [$bits(psu_req_t)-1:0] mid_data;
	logic bk_push;
	psu_res_t bk_res;
	logic res_full;
	logic res_valid;
	psu_res_t res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd1;
			height_q <= 16'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[11:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	psu_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.data_byte(data_byte),
		.full(full),
		.image_width(width_q),
		.image_height(height_q),
		.req_push(fr_push),
		.req_data(fr_req),
		.req_full(mid_full)
	);

	psu_fifo #(
		.DW($bits(psu_req_t)),
		.DEPTH(PSU_REQ_DEPTH)
	) u_req_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(fr_push),
		.push_data(fr_req),
		.full(mid_full),
		.pop(mid_pop),
		.pop_data(mid_data),
		.valid(mid_valid)
	);

	psu_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(mid_valid),
		.req_data(mid_data),
		.req_pop(mid_pop),
		.res_push(bk_push),
		.res_data(bk_res),
		.res_full(res_full)
	);

	psu_fifo #(
		.DW($bits(psu_res_t)),
		.DEPTH(PSU_RES_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(bk_push),
		.push_data(bk_res),
		.full(res_full),
		.pop(pop),
		.pop_data(res_head),
		.valid(res_valid)
	);

	assign empty = !res_valid;
	assign red = res_head.red;
	assign green = res_head.green;
	assign blue = res_head.blue;
	assign column = res_head.column;
	assign row = res_head.row;
	assign last_pixel = res_head.last_pixel;
	assign status = res_head.status;

endmodule

`default_nettype wire

### src/psu_checker.sv
// Port-level checker for the PNG RGB scanline unfilter and its bind.
`default_nettype none

module psu_checker
	import psu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic [PSU_COL_W-1:0] column,
	input wire logic [PSU_ROW_W-1:0] row,
	input wire logic last_pixel,
	input wire logic status
);

	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (pop && !empty && status) begin
			err_seen_q <= 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable({red, green, blue, column, row,
			last_pixel, status})))
		else $error("result changed while waiting");

	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0 && !last_pixel))
		else $error("error request carries pixel data");

	a_stop_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		err_seen_q |-> empty)
		else $error("result after filter error");

	a_last_next_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_pixel) |=> (empty || (column == '0 && row == '0)))
		else $error("image did not restart at origin");

endmodule

bind png_rgb_scanline_unfilter psu_checker u_psu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.red(red),
	.green(green),
	.blue(blue),
	.column(column),
	.row(row),
	.last_pixel(last_pixel),
	.status(status)
);

`default_nettype wire

### sim/psu_unfilter_check.sv
// Watches the PNG unfilter channels, recomputes every decoded pixel and compares the results.
module psu_unfilter_check
	import psu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic [7:0] data_byte,
	input wire logic empty,
	input wire logic pop,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic [PSU_COL_W-1:0] column,
	input wire logic [PSU_ROW_W-1:0] row,
	input wire logic last_pixel,
	input wire logic status,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [PSU_CFG_IDX_W-1:0] cfg_index,
	input wire logic [PSU_CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int pending,
	output int pixels_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic ST_PIXEL_OK = 1'b0;
	localparam logic ST_BAD_FILTER = 1'b1;

	typedef enum logic [1:0] {SLOT_FILTER, SLOT_RED, SLOT_GREEN, SLOT_BLUE} byte_slot_t;

	logic [23:0] line_buf [PSU_MAX_WIDTH];
	logic [23:0] prev_px;
	logic [23:0] diag_px;
	logic [2:0] cur_filter;
	logic [7:0] red_in;
	logic [7:0] green_in;
	byte_slot_t slot;
	int col_at;
	int row_at;
	bit halted;
	logic [11:0] width_reg;
	logic [15:0] height_reg;
	psu_res_t pixel_q [$];
	int mismatches;
	int decoded;

	function automatic logic [7:0] restore_channel(input logic [2:0] f, input logic [7:0] raw,
		input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		int p;
		int da;
		int db;
		int dc;
		logic [7:0] guess;
		case (f)
			FILT_SUB: guess = a;
			FILT_UP: guess = b;
			FILT_AVG: guess = 8'((int'(a) + int'(b)) / 2);
			FILT_PAETH: begin
				p = int'(a) + int'(b) - int'(c);
				da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
				db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
				dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
				if (da <= db && da <= dc) begin
					guess = a;
				end else if (db <= dc) begin
					guess = b;
				end else begin
					guess = c;
				end
			end
			default: guess = 8'd0;
		endcase
		return raw + guess;
	endfunction

	task automatic take_byte(input logic [7:0] b);
		psu_res_t r;
		int w;
		int h;
		logic [PSU_COL_W-1:0] at_idx;
		logic [23:0] above;
		logic [23:0] left_n;
		logic [23:0] diag_n;
		logic [23:0] px;
		if (halted)
			return;
		case (slot)
			SLOT_FILTER: begin
				if (b > 8'(FILT_PAETH)) begin
					r = '0;
					r.column = PSU_COL_W'(col_at);
					r.row = PSU_ROW_W'(row_at);
					r.status = ST_BAD_FILTER;
					pixel_q.push_back(r);
					halted = 1'b1;
				end else begin
					cur_filter = b[2:0];
					slot = SLOT_RED;
				end
			end
			SLOT_RED: begin
				red_in = b;
				slot = SLOT_GREEN;
			end
			SLOT_GREEN: begin
				green_in = b;
				slot = SLOT_BLUE;
			end
			default: begin
				w = (width_reg == 0) ? 1 :
					((int'(width_reg) > PSU_MAX_WIDTH) ? PSU_MAX_WIDTH : int'(width_reg));
				h = (height_reg == 0) ? 1 : int'(height_reg);
				at_idx = PSU_COL_W'(col_at);
				above = (row_at == 0) ? 24'd0 : line_buf[at_idx];
				left_n = (col_at == 0) ? 24'd0 : prev_px;
				diag_n = (col_at == 0 || row_at == 0) ? 24'd0 : diag_px;
				px[23:16] = restore_channel(cur_filter, red_in, left_n[23:16], above[23:16],
					diag_n[23:16]);
				px[15:8] = restore_channel(cur_filter, green_in, left_n[15:8], above[15:8],
					diag_n[15:8]);
				px[7:0] = restore_channel(cur_filter, b, left_n[7:0], above[7:0], diag_n[7:0]);
				line_buf[at_idx] = px;
				prev_px = px;
				diag_px = above;
				r.red = px[23:16];
				r.green = px[15:8];
				r.blue = px[7:0];
				r.column = PSU_COL_W'(col_at);
				r.row = PSU_ROW_W'(row_at);
				r.status = ST_PIXEL_OK;
				r.last_pixel = 1'b0;
				if (col_at + 1 >= w) begin
					col_at = 0;
					slot = SLOT_FILTER;
					if (row_at + 1 >= h) begin
						row_at = 0;
						r.last_pixel = 1'b1;
					end else begin
						row_at++;
					end
				end else begin
					col_at++;
					slot = SLOT_RED;
				end
				pixel_q.push_back(r);
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic match_pixel();
		psu_res_t e;
		if (pixel_q.size() == 0) begin
			$error("unexpected pixel at column %0d row %0d", column, row);
			mismatches++;
			return;
		end
		e = pixel_q.pop_front();
		decoded++;
		check_field("red", 32'(e.red), 32'(red));
		check_field("green", 32'(e.green), 32'(green));
		check_field("blue", 32'(e.blue), 32'(blue));
		check_field("column", 32'(e.column), 32'(column));
		check_field("row", 32'(e.row), 32'(row));
		check_field("last_pixel", 32'(e.last_pixel), 32'(last_pixel));
		check_field("status", 32'(e.status), 32'(status));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_px = '0;
			diag_px = '0;
			cur_filter = FILT_NONE;
			red_in = '0;
			green_in = '0;
			slot = SLOT_FILTER;
			col_at = 0;
			row_at = 0;
			halted = 1'b0;
			width_reg = 12'd1;
			height_reg = 16'd1;
			pixel_q.delete();
			mismatches = 0;
			decoded = 0;
			fail_count <= 0;
			pending <= 0;
			pixels_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_reg = cfg_data[11:0];
				end else if (cfg_index == REG_IMAGE_HEIGHT) begin
					height_reg = cfg_data;
				end
			end
			if (push && !full)
				take_byte(data_byte);
			if (pop && !empty)
				match_pixel();
			fail_count <= mismatches;
			pending <= pixel_q.size();
			pixels_seen <= decoded;
		end
	end

endmodule

### sim/png_rgb_scanline_unfilter_tb.sv
// Testbench top for the PNG RGB scanline unfilter: byte stream, size settings and verdict.
module png_rgb_scanline_unfilter_tb;
	import psu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 1900;
	localparam int DRAIN_WAIT = 10;
	localparam int LIMIT_CYCLES = 2000000;
	localparam logic [PSU_CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [PSU_CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] data_byte;
	logic empty;
	logic pop;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [PSU_COL_W-1:0] column;
	logic [PSU_ROW_W-1:0] row;
	logic last_pixel;
	logic status;
	logic cfg_valid;
	logic cfg_ready;
	logic [PSU_CFG_IDX_W-1:0] cfg_index;
	logic [PSU_CFG_DATA_W-1:0] cfg_data;
	int fail_count;
	int pending;
	int pixels_seen;

	int cycle_count = 0;
	int bytes_sent = 0;
	int size_changes = 0;
	bit steady = 1'b0;
	int stall_left = 0;

	// stream position as the generator sees it
	logic [11:0] cur_w = 12'd1;
	logic [15:0] cur_h = 16'd1;
	bit at_row_start = 1'b1;
	int col_pos = 0;
	int row_pos = 0;
	int stored_cols = 0;

	png_rgb_scanline_unfilter dut (.*);
	psu_unfilter_check scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycle_count, pending);
			$display("FAIL png_rgb_scanline_unfilter");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int width_of(input logic [11:0] w);
		if (w == 0)
			return 1;
		return (int'(w) > PSU_MAX_WIDTH) ? PSU_MAX_WIDTH : int'(w);
	endfunction

	function automatic int height_of(input logic [15:0] h);
		return (h == 0) ? 1 : int'(h);
	endfunction

	function automatic logic [7:0] channel_value();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(0, 3));
			default: return 8'($urandom);
		endcase
	endfunction

	// result side: pop with random stalls
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if (!steady)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [PSU_CFG_IDX_W-1:0] idx,
		input logic [PSU_CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// new size; past row 0 the width may not exceed the columns already in the line store
	task automatic set_size(input logic [11:0] w, input logic [15:0] h);
		if (row_pos != 0 && width_of(w) > stored_cols)
			w = 12'(stored_cols);
		drain();
		write_reg(REG_IMAGE_WIDTH, {4'($urandom), w});
		write_reg(REG_IMAGE_HEIGHT, h);
		cur_w = w;
		cur_h = h;
		size_changes++;
	endtask

	task automatic advance_stream();
		if (at_row_start) begin
			send_byte(8'($urandom_range(FILT_PAETH, FILT_NONE)));
			at_row_start = 1'b0;
		end else begin
			repeat (3) send_byte(channel_value());
			if (col_pos + 1 > stored_cols)
				stored_cols = col_pos + 1;
			if (col_pos + 1 >= width_of(cur_w)) begin
				col_pos = 0;
				at_row_start = 1'b1;
				if (row_pos + 1 >= height_of(cur_h))
					row_pos = 0;
				else
					row_pos++;
			end else begin
				col_pos++;
			end
		end
	endtask

	// single-pixel image at the 1x1 size
	task automatic send_solo(input logic [2:0] f, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		send_byte(8'(f));
		send_byte(r);
		send_byte(g);
		send_byte(b);
		stored_cols = 1;
	endtask

	initial begin
		int phase;
		int random_start;
		push <= 1'b0;
		data_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size is 1x1: every filter with black neighbours
		send_solo(FILT_NONE, 8'h00, 8'h00, 8'h00);
		send_solo(FILT_NONE, 8'hFF, 8'hFF, 8'hFF);
		send_solo(FILT_SUB, 8'h80, 8'h7F, 8'h01);
		send_solo(FILT_UP, 8'hFE, 8'h01, 8'hAA);
		send_solo(FILT_AVG, 8'h55, 8'hAA, 8'hFF);
		set_size(12'd0, 16'd0);
		send_solo(FILT_PAETH, 8'hFF, 8'h00, 8'h80);

		phase = 0;
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES || phase < 16) begin
			steady = ($urandom_range(0, 3) == 0);
			case (phase % 8)
				0: set_size(12'($urandom_range(1, 6)), 16'($urandom_range(1, 5)));
				1: set_size(12'($urandom_range(7, 24)), 16'($urandom_range(1, 4)));
				2: set_size(12'($urandom_range(1, 3)), 16'hFFFF);
				3: set_size(12'd0, 16'($urandom_range(0, 3)));
				4: set_size(12'd2048, 16'd0);
				5: begin
					set_size(12'($urandom_range(1, 4)), 16'($urandom));
					write_reg(REG_UNMAPPED_LO, 16'($urandom));
					write_reg(REG_UNMAPPED_HI, 16'($urandom));
				end
				6: set_size(12'($urandom_range(2049, 4095)), 16'($urandom_range(1, 3)));
				default: set_size(12'($urandom_range(1, 8)), 16'($urandom_range(2, 10)));
			endcase
			repeat ($urandom_range(10, 40)) advance_stream();
			phase++;
		end

		// bad filter byte at the start of a later row, then bytes that must be dropped
		steady = 1'b0;
		set_size(12'd3, 16'd5);
		while (!(at_row_start && row_pos >= 1)) advance_stream();
		send_byte(8'(FILT_PAETH) + 8'd1);
		repeat (20) send_byte(8'($urandom));
		drain();

		if (pending != 0)
			$error("%0d decoded pixels never came out", pending);
		$display("Streamed %0d bytes over %0d size settings, widths from 1 to %0d columns,",
			bytes_sent, size_changes, PSU_MAX_WIDTH);
		$display("%0d pixels decoded and compared; stream closed by a bad filter byte.",
			pixels_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS png_rgb_scanline_unfilter");
		end else begin
			$display("FAIL png_rgb_scanline_unfilter");
		end
		$finish;
	end

endmodule
